@@ design/brfa_pkg.sv @@
// brfa_pkg: shared constants, codes and control structs for the boot region allocator
// used by brfa_prep, brfa_scan and boot_region_first_fit_allocator
package brfa_pkg;

    localparam int REGION_SLOTS_DEF = 64;
    localparam int PAGE_SHIFT_DEF   = 12;
    localparam int ADDR_BITS_DEF    = 32;

    localparam int FIELD_W    = 32;
    localparam int LG_W       = 5;
    localparam int TOP_W      = 21;
    localparam int STS_W      = 2;
    localparam int IN_TDATA_W = 104;
    localparam int OUT_TDATA_W = 56;
    localparam int CFG_IDX_W  = 1;

    localparam logic [TOP_W-1:0]   TOP_MAX      = 21'h1F_FFFF;
    localparam logic [FIELD_W-1:0] KSTART_RESET = 32'h0010_0000;
    localparam logic [FIELD_W-1:0] KEND_RESET   = 32'h0020_0000;

    localparam logic OP_ADD   = 1'b0;
    localparam logic OP_ALLOC = 1'b1;

    localparam logic [STS_W-1:0] STS_OK   = 2'd0;
    localparam logic [STS_W-1:0] STS_FULL = 2'd1;
    localparam logic [STS_W-1:0] STS_OOM  = 2'd2;

    localparam logic [CFG_IDX_W-1:0] REG_KSTART = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_KEND   = 1'b1;

    typedef struct packed {
        logic keep_page;
        logic p0_vld;
        logic p1_vld;
        logic plain;
    } prep_flags_t;

    typedef struct packed {
        logic load;
        logic alloc;
        logic p0_vld;
        logic p1_vld;
    } scan_cmd_t;

    typedef struct packed {
        logic grant;
        logic left;
    } scan_sts_t;

endpackage

@@ design/boot_region_first_fit_allocator.sv @@
// boot_region_first_fit_allocator: region table with first-fit bump allocation
// depends on brfa_pkg, brfa_prep, brfa_scan, brfa_cell
//
//   channel   direction   beat contents
//   s_        in          tuser opcode, tdata region_start/region_end/request_length/align_log2
//   m_        out         tuser status, tdata alloc_address/top_page
//   cfg_      in          cfg_index register, cfg_data value
//
// an item goes from accept to result in this order: the prep state, then the
// slot ring turns once through the head unit, one slot a cycle, then the result register loads once it is free
// s_tready comes back with the result, so a new item is taken only after the last one is done
// reset is synchronous, clears every slot and the top page, kernel bounds return to defaults
// one finished result may wait on m_tready while the next item runs; the done cycle holds
// while an earlier result still waits
module boot_region_first_fit_allocator #(
    parameter int REGION_SLOTS = brfa_pkg::REGION_SLOTS_DEF,
    parameter int PAGE_SHIFT   = brfa_pkg::PAGE_SHIFT_DEF,
    parameter int ADDR_BITS    = brfa_pkg::ADDR_BITS_DEF
) (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             s_tvalid,
    output logic                             s_tready,
    // region_start, region_end, request_length, align_log2, zero fill
    input  logic [brfa_pkg::IN_TDATA_W-1:0]  s_tdata,
    // opcode
    input  logic                             s_tuser,
    output logic                             m_tvalid,
    input  logic                             m_tready,
    // alloc_address, top_page, zero fill
    output logic [brfa_pkg::OUT_TDATA_W-1:0] m_tdata,
    // status
    output logic [brfa_pkg::STS_W-1:0]       m_tuser,
    input  logic                             cfg_valid,
    output logic                             cfg_ready,
    input  logic [brfa_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [brfa_pkg::FIELD_W-1:0]     cfg_data
);
    import brfa_pkg::*;

    localparam int AW    = ADDR_BITS;
    localparam int CNT_W = $clog2(REGION_SLOTS);

    typedef enum logic [3:0] {
        ST_IDLE = 4'b0001,
        ST_PREP = 4'b0010,
        ST_SCAN = 4'b0100,
        ST_DONE = 4'b1000
    } state_t;

    state_t             state_reg, state_next;
    logic [CNT_W-1:0]   cnt_reg, cnt_next;
    logic               op_reg, op_next;
    logic [FIELD_W-1:0] rs_reg, rs_next, re_reg, re_next, len_reg, len_next;
    logic [LG_W-1:0]    lg_reg, lg_next;
    logic               plain_reg, plain_next;
    logic [TOP_W-1:0]   maxpg_reg, maxpg_next;
    logic [FIELD_W-1:0] kstart_reg, kstart_next, kend_reg, kend_next;
    logic               mval_reg, mval_next;
    logic [STS_W-1:0]   msts_reg, msts_next;
    logic [FIELD_W-1:0] maddr_reg, maddr_next;
    logic [TOP_W-1:0]   mtop_reg, mtop_next;

    prep_flags_t   pflags;
    logic [TOP_W-1:0] ppage;
    logic [AW-1:0] p0_start, p0_stop, p1_start, p1_stop;
    scan_cmd_t     cmd;
    scan_sts_t     sts;
    logic          shift_en, out_free;
    logic [FIELD_W-1:0] grant_addr;
    logic [AW-1:0] head_start, head_stop;
    logic [AW-1:0] cell_start [REGION_SLOTS];
    logic [AW-1:0] cell_stop  [REGION_SLOTS];

    brfa_prep #(
        .AW(AW),
        .PS(PAGE_SHIFT)
    ) u_prep (
        .region_start(rs_reg),
        .region_end  (re_reg),
        .kstart      (kstart_reg),
        .kend        (kend_reg),
        .flags       (pflags),
        .page        (ppage),
        .p0_start    (p0_start),
        .p0_stop     (p0_stop),
        .p1_start    (p1_start),
        .p1_stop     (p1_stop)
    );

    brfa_scan #(
        .AW(AW)
    ) u_scan (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cmd           (cmd),
        .shift_en      (shift_en),
        .p0_start      (p0_start),
        .p0_stop       (p0_stop),
        .p1_start      (p1_start),
        .p1_stop       (p1_stop),
        .req_len       (len_reg),
        .req_lg        (lg_reg),
        .slot_in_start (cell_start[0]),
        .slot_in_stop  (cell_stop[0]),
        .slot_out_start(head_start),
        .slot_out_stop (head_stop),
        .sts           (sts),
        .grant_addr    (grant_addr)
    );

    // cell 0 feeds the head unit, the head unit refills the far end of the ring
    for (genvar i = 0; i < REGION_SLOTS; i++) begin : g_cell
        if (i == REGION_SLOTS - 1) begin : g_tail
            brfa_cell #(.AW(AW)) u_cell (
                .aclk     (aclk),
                .aresetn  (aresetn),
                .shift_en (shift_en),
                .nxt_start(head_start),
                .nxt_stop (head_stop),
                .cur_start(cell_start[i]),
                .cur_stop (cell_stop[i])
            );
        end else begin : g_body
            brfa_cell #(.AW(AW)) u_cell (
                .aclk     (aclk),
                .aresetn  (aresetn),
                .shift_en (shift_en),
                .nxt_start(cell_start[i+1]),
                .nxt_stop (cell_stop[i+1]),
                .cur_start(cell_start[i]),
                .cur_stop (cell_stop[i])
            );
        end
    end

    assign s_tready  = state_reg == ST_IDLE;
    assign cfg_ready = 1'b1;
    assign shift_en  = state_reg == ST_SCAN;
    assign out_free  = !mval_reg || m_tready;

    always_comb begin
        cmd.load   = state_reg == ST_PREP;
        cmd.alloc  = op_reg == OP_ALLOC;
        cmd.p0_vld = (op_reg == OP_ADD) && pflags.p0_vld;
        cmd.p1_vld = (op_reg == OP_ADD) && pflags.p1_vld;
    end

    always_comb begin
        state_next  = state_reg;
        cnt_next    = cnt_reg;
        op_next     = op_reg;
        rs_next     = rs_reg;
        re_next     = re_reg;
        len_next    = len_reg;
        lg_next     = lg_reg;
        plain_next  = plain_reg;
        maxpg_next  = maxpg_reg;
        kstart_next = kstart_reg;
        kend_next   = kend_reg;
        mval_next   = mval_reg;
        msts_next   = msts_reg;
        maddr_next  = maddr_reg;
        mtop_next   = mtop_reg;

        if (mval_reg && m_tready) begin
            mval_next = 1'b0;
        end

        if (cfg_valid && cfg_ready) begin
            case (cfg_index)
                REG_KSTART: kstart_next = cfg_data;
                REG_KEND:   kend_next   = cfg_data;
                default:    ;
            endcase
        end

        case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    op_next    = s_tuser;
                    rs_next    = s_tdata[31:0];
                    re_next    = s_tdata[63:32];
                    len_next   = s_tdata[95:64];
                    lg_next    = s_tdata[100:96];
                    state_next = ST_PREP;
                end
            end
            ST_PREP: begin
                plain_next = (op_reg == OP_ADD) && pflags.plain;
                if ((op_reg == OP_ADD) && pflags.keep_page && (ppage > maxpg_reg)) begin
                    maxpg_next = ppage;
                end
                cnt_next   = '0;
                state_next = ST_SCAN;
            end
            ST_SCAN: begin
                cnt_next = cnt_reg + CNT_W'(1);
                if (cnt_reg == CNT_W'(REGION_SLOTS - 1)) begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE: begin
                if (out_free) begin
                    mval_next  = 1'b1;
                    mtop_next  = maxpg_reg;
                    maddr_next = '0;
                    msts_next  = STS_OK;
                    if (op_reg == OP_ALLOC) begin
                        if (sts.grant) begin
                            maddr_next = grant_addr;
                        end else begin
                            msts_next = STS_OOM;
                        end
                    end else if (plain_reg && sts.left) begin
                        msts_next = STS_FULL;
                    end
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg  <= ST_IDLE;
            cnt_reg    <= '0;
            plain_reg  <= 1'b0;
            maxpg_reg  <= '0;
            kstart_reg <= KSTART_RESET;
            kend_reg   <= KEND_RESET;
            mval_reg   <= 1'b0;
        end else begin
            state_reg  <= state_next;
            cnt_reg    <= cnt_next;
            plain_reg  <= plain_next;
            maxpg_reg  <= maxpg_next;
            kstart_reg <= kstart_next;
            kend_reg   <= kend_next;
            mval_reg   <= mval_next;
        end
    end

    always_ff @(posedge aclk) begin
        op_reg    <= op_next;
        rs_reg    <= rs_next;
        re_reg    <= re_next;
        len_reg   <= len_next;
        lg_reg    <= lg_next;
        msts_reg  <= msts_next;
        maddr_reg <= maddr_next;
        mtop_reg  <= mtop_next;
    end

    assign m_tvalid = mval_reg;
    assign m_tuser  = msts_reg;
    assign m_tdata  = {3'b000, mtop_reg, maddr_reg};

    // the ring turns exactly once per item
    a_scan_len: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_SCAN && cnt_reg == CNT_W'(REGION_SLOTS - 1)) |=> state_reg == ST_DONE)
        else $error("slot ring did not finish after one turn");

    // a finished item lands in a free result register
    a_done_out: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_DONE && out_free) |=> (m_tvalid && state_reg == ST_IDLE))
        else $error("result beat not loaded");

    // a failed allocation never carries an address
    a_oom_addr: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tuser == STS_OOM) |-> m_tdata[31:0] == '0)
        else $error("out of memory beat with nonzero address");

endmodule

@@ design/brfa_cell.sv @@
// brfa_cell: one region slot of the rotating slot ring
// depends on nothing but its parameter; neighbors are wired in the top level
module brfa_cell #(
    parameter int AW = 32
) (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          shift_en,
    input  logic [AW-1:0] nxt_start,
    input  logic [AW-1:0] nxt_stop,
    output logic [AW-1:0] cur_start,
    output logic [AW-1:0] cur_stop
);

    logic [AW-1:0] start_reg, start_next;
    logic [AW-1:0] stop_reg, stop_next;

    always_comb begin
        start_next = start_reg;
        stop_next  = stop_reg;
        if (shift_en) begin
            start_next = nxt_start;
            stop_next  = nxt_stop;
        end
    end

    // empty slot reads as start 0
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            start_reg <= '0;
            stop_reg  <= '0;
        end else begin
            start_reg <= start_next;
            stop_reg  <= stop_next;
        end
    end

    assign cur_start = start_reg;
    assign cur_stop  = stop_reg;

endmodule

@@ design/brfa_prep.sv @@
// brfa_prep: page rounding of an added region and cutting out the kernel image
// depends on brfa_pkg
module brfa_prep #(
    parameter int AW = 32,
    parameter int PS = 12
) (
    input  logic [brfa_pkg::FIELD_W-1:0] region_start,
    input  logic [brfa_pkg::FIELD_W-1:0] region_end,
    input  logic [brfa_pkg::FIELD_W-1:0] kstart,
    input  logic [brfa_pkg::FIELD_W-1:0] kend,
    output brfa_pkg::prep_flags_t        flags,
    output logic [brfa_pkg::TOP_W-1:0]   page,
    output logic [AW-1:0]                p0_start,
    output logic [AW-1:0]                p0_stop,
    output logic [AW-1:0]                p1_start,
    output logic [AW-1:0]                p1_stop
);
    import brfa_pkg::*;

    localparam int CW = ((AW > FIELD_W) ? AW : FIELD_W) + 1;
    localparam logic [CW-1:0] AMASK = {CW{1'b1}} >> (CW - AW);
    localparam logic [CW-1:0] PGB   = CW'(1) << PS;
    localparam logic [CW-1:0] PGM   = PGB - CW'(1);

    logic [CW-1:0] s_w, e_w, s_up, e_dn, s_eff, ks, ke, page_w;
    logic          over_top, zero_s, live, in_kernel, overlap, keep;

    always_comb begin
        s_w      = CW'(region_start) & AMASK;
        e_w      = CW'(region_end) & AMASK;
        s_up     = (s_w + PGM) & ~PGM;
        e_dn     = e_w & ~PGM;
        over_top = (s_up & ~AMASK) != '0;
        zero_s   = s_up == '0;
        s_eff    = zero_s ? PGB : s_up;
        live     = !over_top && !(zero_s && (s_eff >= e_dn));

        page_w = e_dn >> PS;
        page   = (page_w > CW'(TOP_MAX)) ? TOP_MAX : page_w[TOP_W-1:0];

        ks = CW'(kstart) & AMASK & ~PGM;
        ke = ((CW'(kend) & AMASK) + PGM) & ~PGM;

        in_kernel = (s_eff >= ks) && (e_dn < ke);
        overlap   = ((s_eff < ke) && (e_dn >= ke)) || ((s_eff <= ks) && (e_dn > ks));
        keep      = live && !in_kernel;

        flags.keep_page = live;
        flags.p0_vld    = keep && (overlap ? (s_eff < ks) : 1'b1);
        flags.p1_vld    = keep && overlap && (e_dn > ke);
        flags.plain     = keep && !overlap;

        p0_start = s_eff[AW-1:0];
        p0_stop  = overlap ? ks[AW-1:0] : e_dn[AW-1:0];
        p1_start = ke[AW-1:0];
        p1_stop  = e_dn[AW-1:0];
    end

endmodule

@@ design/brfa_scan.sv @@
// brfa_scan: head unit of the slot ring, places pending pieces or grants an allocation
// as each slot passes by; depends on brfa_pkg
module brfa_scan #(
    parameter int AW = 32
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  brfa_pkg::scan_cmd_t          cmd,
    input  logic                         shift_en,
    input  logic [AW-1:0]                p0_start,
    input  logic [AW-1:0]                p0_stop,
    input  logic [AW-1:0]                p1_start,
    input  logic [AW-1:0]                p1_stop,
    input  logic [brfa_pkg::FIELD_W-1:0] req_len,
    input  logic [brfa_pkg::LG_W-1:0]    req_lg,
    input  logic [AW-1:0]                slot_in_start,
    input  logic [AW-1:0]                slot_in_stop,
    output logic [AW-1:0]                slot_out_start,
    output logic [AW-1:0]                slot_out_stop,
    output brfa_pkg::scan_sts_t          sts,
    output logic [brfa_pkg::FIELD_W-1:0] grant_addr
);
    import brfa_pkg::*;

    localparam int CW = ((AW > FIELD_W) ? AW : FIELD_W) + 1;

    logic                alloc_reg, alloc_next;
    logic                p0v_reg, p0v_next;
    logic                p1v_reg, p1v_next;
    logic                grant_reg, grant_next;
    logic [AW-1:0]       p0s_reg, p0s_next, p0e_reg, p0e_next;
    logic [AW-1:0]       p1s_reg, p1s_next, p1e_reg, p1e_next;
    logic [CW-1:0]       amask_reg, amask_next;
    logic [FIELD_W-1:0]  addr_reg, addr_next;

    logic [CW-1:0] first, last, bumped;
    logic          empty, fits, take_alloc, take_p0, take_p1;

    always_comb begin
        empty  = slot_in_start == '0;
        first  = (CW'(slot_in_start) + amask_reg) & ~amask_reg;
        last   = CW'(slot_in_stop) & ~amask_reg;
        fits   = (first < last) && ((last - first) >= CW'(req_len));
        bumped = first + CW'(req_len);

        take_alloc = alloc_reg && !grant_reg && fits;
        take_p0    = !alloc_reg && p0v_reg && empty;
        take_p1    = !alloc_reg && !p0v_reg && p1v_reg && empty;

        slot_out_start = slot_in_start;
        slot_out_stop  = slot_in_stop;
        if (take_alloc) begin
            slot_out_start = bumped[AW-1:0];
        end else if (take_p0) begin
            slot_out_start = p0s_reg;
            slot_out_stop  = p0e_reg;
        end else if (take_p1) begin
            slot_out_start = p1s_reg;
            slot_out_stop  = p1e_reg;
        end
    end

    always_comb begin
        alloc_next = alloc_reg;
        p0v_next   = p0v_reg;
        p1v_next   = p1v_reg;
        grant_next = grant_reg;
        p0s_next   = p0s_reg;
        p0e_next   = p0e_reg;
        p1s_next   = p1s_reg;
        p1e_next   = p1e_reg;
        amask_next = amask_reg;
        addr_next  = addr_reg;
        if (cmd.load) begin
            alloc_next = cmd.alloc;
            p0v_next   = cmd.p0_vld;
            p1v_next   = cmd.p1_vld;
            grant_next = 1'b0;
            p0s_next   = p0_start;
            p0e_next   = p0_stop;
            p1s_next   = p1_start;
            p1e_next   = p1_stop;
            amask_next = (CW'(1) << req_lg) - CW'(1);
        end else if (shift_en) begin
            if (take_alloc) begin
                grant_next = 1'b1;
                addr_next  = first[FIELD_W-1:0];
            end
            if (take_p0) begin
                p0v_next = 1'b0;
            end
            if (take_p1) begin
                p1v_next = 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            alloc_reg <= 1'b0;
            p0v_reg   <= 1'b0;
            p1v_reg   <= 1'b0;
            grant_reg <= 1'b0;
        end else begin
            alloc_reg <= alloc_next;
            p0v_reg   <= p0v_next;
            p1v_reg   <= p1v_next;
            grant_reg <= grant_next;
        end
    end

    always_ff @(posedge aclk) begin
        p0s_reg   <= p0s_next;
        p0e_reg   <= p0e_next;
        p1s_reg   <= p1s_next;
        p1e_reg   <= p1e_next;
        amask_reg <= amask_next;
        addr_reg  <= addr_next;
    end

    assign sts.grant  = grant_reg;
    assign sts.left   = p0v_reg || p1v_reg;
    assign grant_addr = addr_reg;

endmodule
